/* rtl/sbedc_pkg.sv */
// Shared types, constants and the EDC byte update function for the sampled-byte CRC and sum unit.
package sbedc_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int LANES   = WORD_W / BYTE_W;
    localparam int LANE_W  = $clog2(LANES);

    // Reflected CD-ROM EDC polynomial.
    localparam logic [WORD_W-1:0] EDC_POLY = 32'hD801_8001;

    // One sampled byte on its way from the input stage to the accumulators.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [BYTE_W-1:0] sample;
    } sample_t;

    // One byte of reflected CRC, least significant bit first.
    function automatic logic [WORD_W-1:0] edc_update(
        input logic [WORD_W-1:0] crc,
        input logic [BYTE_W-1:0] sample
    );
        logic [WORD_W-1:0] c;
        c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, sample};
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ EDC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/sbedc_lane_sel.sv */
// Input stage: lane counter and register for the byte picked out of each word.
module sbedc_lane_sel (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic [sbedc_pkg::WORD_W-1:0]  data_word,
    input  logic                          last_word,
    output sbedc_pkg::sample_t            stage,
    output logic [sbedc_pkg::LANE_W-1:0]  lane_count
);
    import sbedc_pkg::*;

    logic [LANE_W-1:0] lane_reg;
    logic [LANE_W-1:0] lane_next;
    logic              valid_reg;
    logic              valid_next;
    logic              last_reg;
    logic [BYTE_W-1:0] sample_reg;
    logic [BYTE_W-1:0] sample_next;

    // Pick the byte of the current lane; the lane restarts after a last word.
    always_comb
    begin
        sample_next = data_word[lane_reg*BYTE_W +: BYTE_W];
        lane_next   = lane_reg;
        valid_next  = valid_reg;
        if (advance)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                lane_next = last_word ? '0 : lane_reg + 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            lane_reg  <= lane_next;
            valid_reg <= valid_next;
        end
    end

    // Payload of the stage register.
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            sample_reg <= sample_next;
            last_reg   <= last_word;
        end
    end

    assign stage.valid  = valid_reg;
    assign stage.last   = last_reg;
    assign stage.sample = sample_reg;
    assign lane_count   = lane_reg;

endmodule

/* rtl/sbedc_accum.sv */
// Running CRC and sum accumulators with the result register.
module sbedc_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbedc_pkg::sample_t            stage,
    input  logic                          out_stall,
    output logic                          advance,
    output logic                          out_valid,
    output logic [sbedc_pkg::WORD_W-1:0]  crc_value,
    output logic [sbedc_pkg::WORD_W-1:0]  byte_sum
);
    import sbedc_pkg::*;

    logic [WORD_W-1:0] crc_reg;
    logic [WORD_W-1:0] crc_next;
    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic [WORD_W-1:0] res_crc_reg;
    logic [WORD_W-1:0] res_sum_reg;
    logic              take;

    // The pipeline moves whenever the result register is empty or being read.
    assign advance = !res_valid_reg || !out_stall;
    assign take    = advance && stage.valid;

    // Byte update of both running values.
    always_comb
    begin
        crc_next       = edc_update(crc_reg, stage.sample);
        sum_next       = sum_reg + {{(WORD_W-BYTE_W){1'b0}}, stage.sample};
        res_valid_next = advance ? (stage.valid && stage.last) : res_valid_reg;
    end

    // Accumulators clear after the last word of a buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            sum_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                crc_reg <= stage.last ? '0 : crc_next;
                sum_reg <= stage.last ? '0 : sum_next;
            end
        end
    end

    // Result payload is loaded on the transfer of a last word.
    always_ff @(posedge clk)
    begin
        if (take && stage.last)
        begin
            res_crc_reg <= crc_next;
            res_sum_reg <= sum_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign crc_value = res_crc_reg;
    assign byte_sum  = res_sum_reg;

endmodule

/* rtl/sampled_byte_edc_crc_and_sum_unit.sv */
// Top level: sampled-byte EDC CRC-32 and byte sum over a stream of words.
// A last word's result becomes valid after passing the input stage register, then the result register.
// Throughput: one word per cycle unless stalled, set by the stage and result registers.
// The input stalls only while a result waits in the result register and is itself stalled.
// Reset (rst_n, asynchronous, active low) clears the lane counter, CRC, sum and valid flags.
module sampled_byte_edc_crc_and_sum_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sbedc_pkg::WORD_W-1:0]  data_word,
    input  logic                          last_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sbedc_pkg::WORD_W-1:0]  crc_value,
    output logic [sbedc_pkg::WORD_W-1:0]  byte_sum
);
    import sbedc_pkg::*;

    sample_t           stage;
    logic              advance;
    logic [LANE_W-1:0] lane_count;

    assign in_stall = !advance;

    // Lane selection and input stage register.
    sbedc_lane_sel u_lane_sel (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (in_valid),
        .data_word  (data_word),
        .last_word  (last_word),
        .stage      (stage),
        .lane_count (lane_count)
    );

    // CRC and sum accumulation with the result register.
    sbedc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .out_stall (out_stall),
        .advance   (advance),
        .out_valid (out_valid),
        .crc_value (crc_value),
        .byte_sum  (byte_sum)
    );

`ifndef SYNTHESIS
    // An empty result register never holds back the input.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result pending");

    // A transfer of a last word restarts the lane count.
    a_lane_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_word) |=> (lane_count == '0))
        else $error("lane count not restarted after last word");

    // A new result comes only from a last word in the stage register.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(stage.valid && stage.last))
        else $error("result appeared without a last word");
`endif

endmodule
